// ===== rtl/swfrm_pkg.sv =====
// Shared widths, constants and state type of the sliding-window frame rate meter.
`default_nettype none

package swfrm_pkg;

    // Field widths
    localparam int TS_W       = 63;   // timestamp and span width
    localparam int CNT_W      = 32;   // frame counter width
    localparam int FPS_W      = 32;   // 16.16 rate width
    localparam int NUM_W      = 64;   // dividend width of the rate division
    localparam int IN_DATA_W  = 64;   // input tdata, padded to bytes
    localparam int OUT_DATA_W = 128;  // output tdata, padded to bytes

    // Rate scaling
    localparam logic [NUM_W-1:0] US_PER_SECOND = 64'd1000000;
    localparam logic [NUM_W-1:0] FRAC_ONE      = 64'd65536;

    // Reset value of the report threshold in microseconds
    localparam logic [31:0] REPORT_SPAN_RESET = 32'd6000000;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_frame_rate_meter.sv =====
// Top level of the sliding-window frame rate meter: ring sequencer, counters and output register.
//
// Each request on the s_axis channel carries one frame timestamp in microseconds.
// The timestamp is written into a ring of HISTORY_DEPTH entries held in a RAM; in the
// same cycle the oldest entry is read. Once the ring has wrapped, each frame measures
// the span from oldest to newest and emits a report on m_axis when the span reaches the
// report threshold (i_cfg_wdata, written with i_cfg_we) or the frame count is a multiple
// of HISTORY_DEPTH. The report gives (HISTORY_DEPTH-1)*1e6/span in unsigned 16.16,
// saturating to all ones, together with the span and the wrapping frame count.
// One request is in work at a time. A frame that gives no report passes the accept and
// the RAM read only; a frame with a report goes on to the 64-step bit-serial divider, one
// quotient bit a cycle, and then to the load into the output register.
// Back-to-back accesses to the ring never overlap, so no forwarding is needed.
// A result waits in the output register while the next request is taken; if the
// receiver stalls with that register full, a finished division waits and s_axis_tready
// stays low. Reset clears the counters, the ring-full flag and the output valid, and
// restores the threshold to 6000000 us; the ring contents are not cleared.
`default_nettype none

module sliding_window_frame_rate_meter #(
    parameter int HISTORY_DEPTH = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration: report_span_us
    input  wire                                i_cfg_we,
    input  wire  [31:0]                        i_cfg_wdata,
    // input stream
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [swfrm_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [62:0] timestamp_us, [63] zero
    // output stream
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [swfrm_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // [31:0] frames_per_second,
                                                               // [94:32] window_span_us,
                                                               // [126:95] frame_total, [127] zero
);

    localparam int TS_W   = swfrm_pkg::TS_W;
    localparam int CNT_W  = swfrm_pkg::CNT_W;
    localparam int FPS_W  = swfrm_pkg::FPS_W;
    localparam int NUM_W  = swfrm_pkg::NUM_W;
    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int OUT_USED_W = FPS_W + TS_W + CNT_W;

    localparam logic [NUM_W-1:0] RATE_NUM =
        NUM_W'(HISTORY_DEPTH - 1) * swfrm_pkg::US_PER_SECOND * swfrm_pkg::FRAC_ONE;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

    swfrm_pkg::t_state r_state, n_state;

    logic [31:0]       r_report_span;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_count_mod, n_count_mod;   // frame counter modulo the depth
    logic [CNT_W-1:0]  r_frame_count, n_frame_count;
    logic              r_filled, n_filled;
    logic              r_was_filled, n_was_filled;
    logic [TS_W-1:0]   r_now, n_now;
    logic [TS_W-1:0]   r_span, n_span;
    logic              r_out_valid, n_out_valid;
    logic [swfrm_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic              accept;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic [FPS_W-1:0]  div_quotient;
    logic [SLOT_W-1:0] oldest_slot;
    logic [TS_W-1:0]   ring_rdata;
    logic [TS_W-1:0]   span_c;
    logic              due;
    logic              load_out;

    assign s_axis_tready = (r_state == swfrm_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign oldest_slot   = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;

    // timestamp ring: write the new entry, read the oldest in the same cycle
    swfrm_ram #(
        .WIDTH (TS_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_slot),
        .i_wdata (s_axis_tdata[TS_W-1:0]),
        .i_re    (accept),
        .i_raddr (oldest_slot),
        .o_rdata (ring_rdata)
    );

    // rate division
    swfrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (RATE_NUM),
        .i_divisor  (span_c),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // span and report decision
    assign span_c = r_now - ring_rdata;
    assign due    = ({{(TS_W-32){1'b0}}, r_report_span} <= span_c) || (r_count_mod == '0);

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_slot        = r_slot;
        n_count_mod   = r_count_mod;
        n_frame_count = r_frame_count;
        n_filled      = r_filled;
        n_was_filled  = r_was_filled;
        n_now         = r_now;
        n_span        = r_span;
        div_start     = 1'b0;
        load_out      = 1'b0;

        case (r_state)
            swfrm_pkg::S_IDLE: begin
                if (accept) begin
                    n_now         = s_axis_tdata[TS_W-1:0];
                    n_frame_count = r_frame_count + 1'b1;
                    // the modulo count restarts when the 32-bit counter wraps
                    if (r_frame_count == '1 || r_count_mod == SLOT_LAST) begin
                        n_count_mod = '0;
                    end else begin
                        n_count_mod = r_count_mod + 1'b1;
                    end
                    n_was_filled = r_filled;
                    if (r_slot == SLOT_LAST) begin
                        n_slot   = '0;
                        n_filled = 1'b1;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                    n_state = swfrm_pkg::S_READ;
                end
            end
            swfrm_pkg::S_READ: begin
                n_span = span_c;
                if (r_was_filled && due) begin
                    div_start = 1'b1;
                    n_state   = swfrm_pkg::S_DIV;
                end else begin
                    n_state = swfrm_pkg::S_IDLE;
                end
            end
            swfrm_pkg::S_DIV: begin
                if (div_done) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = swfrm_pkg::S_IDLE;
                    end else begin
                        n_state = swfrm_pkg::S_HOLD;
                    end
                end
            end
            swfrm_pkg::S_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = swfrm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swfrm_pkg::S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_data  = {{(swfrm_pkg::OUT_DATA_W-OUT_USED_W){1'b0}},
                           r_frame_count, r_span, div_quotient};
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= swfrm_pkg::S_IDLE;
            r_report_span <= swfrm_pkg::REPORT_SPAN_RESET;
            r_slot        <= '0;
            r_count_mod   <= '0;
            r_frame_count <= '0;
            r_filled      <= 1'b0;
            r_was_filled  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            if (i_cfg_we) begin
                r_report_span <= i_cfg_wdata;
            end
            r_slot        <= n_slot;
            r_count_mod   <= n_count_mod;
            r_frame_count <= n_frame_count;
            r_filled      <= n_filled;
            r_was_filled  <= n_was_filled;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_span     <= n_span;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/swfrm_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module swfrm_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swfrm_div.sv =====
// Bit-serial restoring divider producing a saturated 32-bit quotient.
`default_nettype none

module swfrm_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [swfrm_pkg::NUM_W-1:0]      i_dividend,
    input  wire  [swfrm_pkg::TS_W-1:0]       i_divisor,
    output logic                             o_done,
    output logic [swfrm_pkg::FPS_W-1:0]      o_quotient
);

    localparam int NUM_W = swfrm_pkg::NUM_W;
    localparam int TS_W  = swfrm_pkg::TS_W;
    localparam int FPS_W = swfrm_pkg::FPS_W;
    localparam int STEP_W = $clog2(NUM_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [TS_W-1:0]   r_rem, n_rem;
    logic [TS_W-1:0]   r_div, n_div;
    logic [NUM_W-1:0]  r_nq, n_nq;     // dividend shifts out at the top, quotient in at the bottom

    logic [TS_W:0]     rem_sh;
    logic [TS_W:0]     rem_diff;
    logic              take;

    // one quotient bit per cycle
    always_comb begin
        rem_sh   = {r_rem, r_nq[NUM_W-1]};
        rem_diff = rem_sh - {1'b0, r_div};
        take     = (rem_sh >= {1'b0, r_div});

        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_div  = r_div;
        n_nq   = r_nq;

        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(NUM_W - 1);
            n_rem  = '0;
            n_div  = i_divisor;
            n_nq   = i_dividend;
        end else if (r_busy) begin
            n_rem = take ? rem_diff[TS_W-1:0] : rem_sh[TS_W-1:0];
            n_nq  = {r_nq[NUM_W-2:0], take};
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_nq   <= n_nq;
    end

    // a quotient that does not fit in 32 bits saturates; a zero divisor gives all ones too
    assign o_done     = r_done;
    assign o_quotient = (|r_nq[NUM_W-1:FPS_W]) ? '1 : r_nq[FPS_W-1:0];

endmodule

`default_nettype wire
